// File: rtl/stc_pkg.sv
package stc_pkg;

  // Input operation codes
  localparam logic [2:0] OP_TICK        = 3'd0;
  localparam logic [2:0] OP_COMMAND     = 3'd1;
  localparam logic [2:0] OP_TOGGLE      = 3'd2;
  localparam logic [2:0] OP_LEARN_START = 3'd3;
  localparam logic [2:0] OP_LEARN_ABORT = 3'd4;

  // Register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_ANGLE_A_CLOSED = 3'd0;
  localparam logic [2:0] REG_ANGLE_A_THROWN = 3'd1;
  localparam logic [2:0] REG_ANGLE_B_CLOSED = 3'd2;
  localparam logic [2:0] REG_ANGLE_B_THROWN = 3'd3;
  localparam logic [2:0] REG_RELAY_PULSE    = 3'd4;
  localparam logic [2:0] REG_STEP_DELAY     = 3'd5;

  localparam int unsigned CFG_AW = 5;

  // Reset values
  localparam logic [7:0]  RST_ANGLE_CLOSED = 8'd80;
  localparam logic [7:0]  RST_ANGLE_THROWN = 8'd120;
  localparam logic [7:0]  RST_RELAY_PULSE  = 8'd75;
  localparam logic [7:0]  RST_STEP_DELAY   = 8'd50;
  localparam logic [7:0]  RST_ANGLE        = 8'd80;
  localparam logic [10:0] RST_ADDR_A       = 11'd3;
  localparam logic [10:0] RST_ADDR_B       = 11'd4;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_TO_MID = 4'b0010,
    PH_PULSE  = 4'b0100,
    PH_TO_END = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] angle_a_closed;
    logic [7:0] angle_a_thrown;
    logic [7:0] angle_b_closed;
    logic [7:0] angle_b_thrown;
    logic [7:0] relay_pulse_ticks;
    logic [7:0] step_delay_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] closed;
    logic [7:0] thrown;
    logic [7:0] pulse;
    logic [7:0] delay;
  } chan_cfg_t;

  typedef struct packed {
    logic tick;
    logic start;
    logic flip;
    logic dir;
  } chan_cmd_t;

  typedef struct packed {
    logic [7:0] angle;
    logic       state;
    phase_t     phase;
  } chan_view_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [10:0] dcc_address;
    logic        direction;
    logic        channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  servo_a_angle;
    logic [7:0]  servo_b_angle;
    logic [3:0]  relay_drive;
    logic [3:0]  led_drive;
    logic [1:0]  switch_states;
    logic [1:0]  moving;
    logic        learning_active;
    logic [10:0] address_a_out;
    logic [10:0] address_b_out;
  } out_item_t;

  // One degree toward the goal, or stay when already there.
  function automatic logic [7:0] toward(input logic [7:0] a, input logic [7:0] goal);
    logic [7:0] r;
    r = a;
    if (a < goal) r = a + 8'd1;
    else if (a > goal) r = a - 8'd1;
    return r;
  endfunction

endpackage

// File: rtl/stc_if.sv
interface stc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [10:0] dcc_address;
  logic        direction;
  logic        channel;

  modport source (output valid, output op, output dcc_address, output direction,
                  output channel, input ready);
  modport sink (input valid, input op, input dcc_address, input direction,
                input channel, output ready);
endinterface

interface stc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  servo_a_angle;
  logic [7:0]  servo_b_angle;
  logic [3:0]  relay_drive;
  logic [3:0]  led_drive;
  logic [1:0]  switch_states;
  logic [1:0]  moving;
  logic        learning_active;
  logic [10:0] address_a_out;
  logic [10:0] address_b_out;

  modport source (output valid, output servo_a_angle, output servo_b_angle,
                  output relay_drive, output led_drive, output switch_states,
                  output moving, output learning_active, output address_a_out,
                  output address_b_out, input ready);
  modport sink (input valid, input servo_a_angle, input servo_b_angle,
                input relay_drive, input led_drive, input switch_states,
                input moving, input learning_active, input address_a_out,
                input address_b_out, output ready);
endinterface

// File: rtl/stc_regs.sv
module stc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output stc_pkg::cfg_regs_t        regs
);
  import stc_pkg::*;

  cfg_regs_t  regs_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign regs   = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.angle_a_closed    <= RST_ANGLE_CLOSED;
      regs_r.angle_a_thrown    <= RST_ANGLE_THROWN;
      regs_r.angle_b_closed    <= RST_ANGLE_CLOSED;
      regs_r.angle_b_thrown    <= RST_ANGLE_THROWN;
      regs_r.relay_pulse_ticks <= RST_RELAY_PULSE;
      regs_r.step_delay_ticks  <= RST_STEP_DELAY;
    end else if (wr_en) begin
      case (idx)
        REG_ANGLE_A_CLOSED: regs_r.angle_a_closed    <= pwdata[7:0];
        REG_ANGLE_A_THROWN: regs_r.angle_a_thrown    <= pwdata[7:0];
        REG_ANGLE_B_CLOSED: regs_r.angle_b_closed    <= pwdata[7:0];
        REG_ANGLE_B_THROWN: regs_r.angle_b_thrown    <= pwdata[7:0];
        REG_RELAY_PULSE:    regs_r.relay_pulse_ticks <= pwdata[7:0];
        REG_STEP_DELAY:     regs_r.step_delay_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ANGLE_A_CLOSED: prdata = {24'd0, regs_r.angle_a_closed};
      REG_ANGLE_A_THROWN: prdata = {24'd0, regs_r.angle_a_thrown};
      REG_ANGLE_B_CLOSED: prdata = {24'd0, regs_r.angle_b_closed};
      REG_ANGLE_B_THROWN: prdata = {24'd0, regs_r.angle_b_thrown};
      REG_RELAY_PULSE:    prdata = {24'd0, regs_r.relay_pulse_ticks};
      REG_STEP_DELAY:     prdata = {24'd0, regs_r.step_delay_ticks};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/stc_channel.sv
module stc_channel (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  stc_pkg::chan_cmd_t  cmd,
  input  stc_pkg::chan_cfg_t  cfg,
  output stc_pkg::chan_view_t cur,
  output stc_pkg::chan_view_t nxt
);
  import stc_pkg::*;

  logic       state_r, state_nxt;
  logic [7:0] angle_r, angle_nxt;
  phase_t     phase_r, phase_nxt;
  logic [7:0] mid_r, mid_nxt;
  logic [7:0] wait_r, wait_nxt;

  logic       new_st;
  logic [7:0] tgt;
  logic [7:0] end_angle;
  logic [8:0] up_span;
  logic [8:0] dn_span;
  logic [7:0] wait_dec;
  logic       act;

  always_comb begin
    state_nxt = state_r;
    angle_nxt = angle_r;
    phase_nxt = phase_r;
    mid_nxt   = mid_r;
    wait_nxt  = wait_r;
    act       = 1'b0;

    new_st    = cmd.flip ? ~state_r : cmd.dir;
    tgt       = new_st ? cfg.thrown : cfg.closed;
    // The end angle is read live, so a register write during a move is followed.
    end_angle = state_r ? cfg.thrown : cfg.closed;
    up_span   = {1'b0, tgt} - {1'b0, angle_r} + 9'd1;
    dn_span   = {1'b0, angle_r} - {1'b0, tgt} + 9'd1;
    wait_dec  = wait_r - 8'd1;

    if (cmd.start && phase_r == PH_IDLE) begin
      state_nxt = new_st;
      mid_nxt   = (tgt >= angle_r) ? angle_r + up_span[8:1] : angle_r - dn_span[8:1];
      wait_nxt  = 8'd0;
      phase_nxt = PH_TO_MID;
    end else if (cmd.tick && phase_r != PH_IDLE) begin
      if (wait_r != 8'd0) begin
        wait_nxt = wait_dec;
        act      = (wait_dec == 8'd0);
      end else begin
        act = 1'b1;
      end
      if (act) begin
        case (phase_r)
          PH_TO_MID: begin
            if (angle_r == mid_r) begin
              phase_nxt = PH_PULSE;
              wait_nxt  = cfg.pulse;
            end else begin
              angle_nxt = toward(angle_r, mid_r);
              wait_nxt  = cfg.delay;
            end
          end
          PH_PULSE: begin
            phase_nxt = PH_TO_END;
            wait_nxt  = 8'd0;
          end
          PH_TO_END: begin
            if (angle_r == end_angle) begin
              phase_nxt = PH_IDLE;
            end else begin
              angle_nxt = toward(angle_r, end_angle);
              wait_nxt  = cfg.delay;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 1'b0;
      angle_r <= RST_ANGLE;
      phase_r <= PH_IDLE;
      mid_r   <= 8'd0;
      wait_r  <= 8'd0;
    end else if (en) begin
      state_r <= state_nxt;
      angle_r <= angle_nxt;
      phase_r <= phase_nxt;
      mid_r   <= mid_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign cur.angle = angle_r;
  assign cur.state = state_r;
  assign cur.phase = phase_r;
  assign nxt.angle = angle_nxt;
  assign nxt.state = state_nxt;
  assign nxt.phase = phase_nxt;

endmodule

// File: rtl/servo_turnout_controller.sv
// Channel  Direction  Handshake               Carries
// in_ch    in         valid/ready             op, dcc_address, direction, channel
// out_ch   out        valid/ready             angles, relay, LEDs, states, learned addrs
// cfg      in         psel/penable, pready=1  six 8-bit registers at 4*i
//
// An accepted item waits in the input register; when it advances its result is loaded
// into the output register, from which out_ch offers it.
// One item per cycle is sustained while out_ch.ready is high; the single state update
// path between the two registers sets that figure.
// Reset is synchronous on rst_n and restores all state but the item and result data.
// A stalled output holds its result and the input register; in_ch.ready then
// drops once the input register is full.
module servo_turnout_controller (
  input  logic                      clk,
  input  logic                      rst_n,
  stc_in_if.sink                    in_ch,
  stc_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [stc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import stc_pkg::*;

  cfg_regs_t  regs;
  in_item_t   item_r;
  logic       item_valid_r;
  out_item_t  res_r;
  logic       res_valid_r;
  logic       advance;

  logic        learn_r, learn_nxt;
  logic        await_r, await_nxt;
  logic [10:0] addr_a_r, addr_a_nxt;
  logic [10:0] addr_b_r, addr_b_nxt;

  chan_cmd_t  cmd_a, cmd_b;
  chan_cfg_t  cfg_a, cfg_b;
  chan_view_t cur_a, cur_b, nxt_a, nxt_b;
  out_item_t  res_nxt;

  stc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  assign advance     = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op          <= in_ch.op;
      item_r.dcc_address <= in_ch.dcc_address;
      item_r.direction   <= in_ch.direction;
      item_r.channel     <= in_ch.channel;
    end
  end

  always_comb begin
    learn_nxt  = learn_r;
    await_nxt  = await_r;
    addr_a_nxt = addr_a_r;
    addr_b_nxt = addr_b_r;
    cmd_a      = '0;
    cmd_b      = '0;
    cmd_a.dir  = item_r.direction;
    cmd_b.dir  = item_r.direction;
    case (item_r.op)
      OP_TICK: begin
        cmd_a.tick = 1'b1;
        cmd_b.tick = 1'b1;
      end
      OP_COMMAND: begin
        if (learn_r) begin
          if (!await_r) begin
            addr_a_nxt = item_r.dcc_address;
            await_nxt  = 1'b1;
          end else begin
            addr_b_nxt = item_r.dcc_address;
            await_nxt  = 1'b0;
            learn_nxt  = 1'b0;
          end
        end else if (item_r.dcc_address == addr_a_r) begin
          // A busy channel A swallows the command; it does not fall through to B.
          cmd_a.start = 1'b1;
        end else if (item_r.dcc_address == addr_b_r) begin
          cmd_b.start = 1'b1;
        end
      end
      OP_TOGGLE: begin
        if (!learn_r) begin
          cmd_a.start = !item_r.channel;
          cmd_a.flip  = !item_r.channel;
          cmd_b.start = item_r.channel;
          cmd_b.flip  = item_r.channel;
        end
      end
      OP_LEARN_START: learn_nxt = 1'b1;
      OP_LEARN_ABORT: learn_nxt = 1'b0;
      default: ;
    endcase
  end

  assign cfg_a = '{closed: regs.angle_a_closed, thrown: regs.angle_a_thrown,
                   pulse: regs.relay_pulse_ticks, delay: regs.step_delay_ticks};
  assign cfg_b = '{closed: regs.angle_b_closed, thrown: regs.angle_b_thrown,
                   pulse: regs.relay_pulse_ticks, delay: regs.step_delay_ticks};

  stc_channel u_chan_a (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cmd   (cmd_a),
    .cfg   (cfg_a),
    .cur   (cur_a),
    .nxt   (nxt_a)
  );

  stc_channel u_chan_b (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cmd   (cmd_b),
    .cfg   (cfg_b),
    .cur   (cur_b),
    .nxt   (nxt_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_r  <= 1'b0;
      await_r  <= 1'b0;
      addr_a_r <= RST_ADDR_A;
      addr_b_r <= RST_ADDR_B;
    end else if (advance) begin
      learn_r  <= learn_nxt;
      await_r  <= await_nxt;
      addr_a_r <= addr_a_nxt;
      addr_b_r <= addr_b_nxt;
    end
  end

  always_comb begin
    res_nxt.servo_a_angle   = nxt_a.angle;
    res_nxt.servo_b_angle   = nxt_b.angle;
    res_nxt.relay_drive[1:0] = (nxt_a.phase == PH_PULSE) ?
                               (nxt_a.state ? 2'b10 : 2'b01) : 2'b00;
    res_nxt.relay_drive[3:2] = (nxt_b.phase == PH_PULSE) ?
                               (nxt_b.state ? 2'b10 : 2'b01) : 2'b00;
    res_nxt.led_drive[1:0]  = (nxt_a.phase == PH_IDLE) ?
                              (nxt_a.state ? 2'b10 : 2'b01) : 2'b00;
    res_nxt.led_drive[3:2]  = (nxt_b.phase == PH_IDLE) ?
                              (nxt_b.state ? 2'b10 : 2'b01) : 2'b00;
    res_nxt.switch_states   = {nxt_b.state, nxt_a.state};
    res_nxt.moving          = {nxt_b.phase != PH_IDLE, nxt_a.phase != PH_IDLE};
    res_nxt.learning_active = learn_nxt;
    res_nxt.address_a_out   = addr_a_nxt;
    res_nxt.address_b_out   = addr_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid           = res_valid_r;
  assign out_ch.servo_a_angle   = res_r.servo_a_angle;
  assign out_ch.servo_b_angle   = res_r.servo_b_angle;
  assign out_ch.relay_drive     = res_r.relay_drive;
  assign out_ch.led_drive       = res_r.led_drive;
  assign out_ch.switch_states   = res_r.switch_states;
  assign out_ch.moving          = res_r.moving;
  assign out_ch.learning_active = res_r.learning_active;
  assign out_ch.address_a_out   = res_r.address_a_out;
  assign out_ch.address_b_out   = res_r.address_b_out;

  // With the output register empty, the input side must never stall.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !res_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output register");

  // The servo and its state do not change while its relay is pulsing.
  a_hold_during_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_a.phase == PH_PULSE) |=> $stable({cur_a.state, cur_a.angle}))
    else $error("servo A moved during relay pulse");

  a_hold_during_pulse_b: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cur_b.phase == PH_PULSE) |=> $stable({cur_b.state, cur_b.angle}))
    else $error("servo B moved during relay pulse");

  // A start-learning transaction always leaves learning mode on.
  a_learn_start: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_r.op == OP_LEARN_START) |=> learn_r)
    else $error("learning mode not entered");

endmodule

// File: tb/sv/servo_turnout_controller_tb.sv
package stc_tb_pkg;
  import stc_pkg::*;

  // Tracks the turnout controller state and queues the status word that
  // each accepted transaction should produce.
  class turnout_scoreboard;
    logic [7:0]  regs [6];
    logic        learn_on;
    logic        second_pending;
    logic [10:0] addr_a;
    logic [10:0] addr_b;
    logic        pos_state [2];
    logic [7:0]  angle [2];
    logic [7:0]  midpoint [2];
    logic [7:0]  wait_cnt [2];
    phase_t      phase [2];
    out_item_t   expected_status [$];
    int          errors;

    function new();
      errors = 0;
      regs = '{RST_ANGLE_CLOSED, RST_ANGLE_THROWN, RST_ANGLE_CLOSED, RST_ANGLE_THROWN,
               RST_RELAY_PULSE, RST_STEP_DELAY};
      learn_on = 1'b0;
      second_pending = 1'b0;
      addr_a = RST_ADDR_A;
      addr_b = RST_ADDR_B;
      for (int ch = 0; ch < 2; ch++) begin
        pos_state[ch] = 1'b0;
        angle[ch] = RST_ANGLE;
        midpoint[ch] = 8'd0;
        wait_cnt[ch] = 8'd0;
        phase[ch] = PH_IDLE;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] value);
      if (idx <= REG_STEP_DELAY) regs[idx] = value;
    endfunction

    function logic [7:0] end_angle(int ch, logic st);
      return regs[2 * ch + (st ? 1 : 0)];
    endfunction

    function logic [7:0] nudge(logic [7:0] a, logic [7:0] goal);
      if (a < goal) return a + 8'd1;
      if (a > goal) return a - 8'd1;
      return a;
    endfunction

    function void begin_move(int ch, logic st);
      logic [7:0] target;
      if (phase[ch] != PH_IDLE) return;
      pos_state[ch] = st;
      target = end_angle(ch, st);
      // The midpoint sits half the distance away, rounded up.
      if (target >= angle[ch])
        midpoint[ch] = 8'(int'(angle[ch]) + (int'(target) - int'(angle[ch]) + 1) / 2);
      else
        midpoint[ch] = 8'(int'(angle[ch]) - (int'(angle[ch]) - int'(target) + 1) / 2);
      wait_cnt[ch] = 8'd0;
      phase[ch] = PH_TO_MID;
    endfunction

    function void advance(int ch);
      logic [7:0] target;
      if (phase[ch] == PH_IDLE) return;
      if (wait_cnt[ch] != 8'd0) begin
        wait_cnt[ch] = wait_cnt[ch] - 8'd1;
        if (wait_cnt[ch] != 8'd0) return;
      end
      case (phase[ch])
        PH_TO_MID: begin
          if (angle[ch] == midpoint[ch]) begin
            phase[ch] = PH_PULSE;
            wait_cnt[ch] = regs[REG_RELAY_PULSE];
          end else begin
            angle[ch] = nudge(angle[ch], midpoint[ch]);
            wait_cnt[ch] = regs[REG_STEP_DELAY];
          end
        end
        PH_PULSE: begin
          phase[ch] = PH_TO_END;
          wait_cnt[ch] = 8'd0;
        end
        default: begin
          // The end angle is read from the registers on every step.
          target = end_angle(ch, pos_state[ch]);
          if (angle[ch] == target) begin
            phase[ch] = PH_IDLE;
          end else begin
            angle[ch] = nudge(angle[ch], target);
            wait_cnt[ch] = regs[REG_STEP_DELAY];
          end
        end
      endcase
    endfunction

    function void apply_item(in_item_t it);
      out_item_t  st;
      logic [3:0] relay;
      logic [3:0] led;
      logic [1:0] busy;
      logic [1:0] sw;
      int         idx;
      case (it.op)
        OP_TICK: begin
          advance(0);
          advance(1);
        end
        OP_COMMAND: begin
          if (learn_on) begin
            if (!second_pending) begin
              addr_a = it.dcc_address;
              second_pending = 1'b1;
            end else begin
              addr_b = it.dcc_address;
              second_pending = 1'b0;
              learn_on = 1'b0;
            end
          end else if (it.dcc_address == addr_a) begin
            begin_move(0, it.direction);
          end else if (it.dcc_address == addr_b) begin
            begin_move(1, it.direction);
          end
        end
        OP_TOGGLE: begin
          if (!learn_on) begin_move(int'(it.channel), !pos_state[it.channel]);
        end
        OP_LEARN_START: learn_on = 1'b1;
        OP_LEARN_ABORT: learn_on = 1'b0;
        default: ;
      endcase
      relay = '0;
      led = '0;
      busy = '0;
      sw = '0;
      for (int ch = 0; ch < 2; ch++) begin
        idx = 2 * ch + (pos_state[ch] ? 1 : 0);
        if (phase[ch] == PH_PULSE) relay[idx] = 1'b1;
        if (phase[ch] == PH_IDLE) led[idx] = 1'b1;
        else busy[ch] = 1'b1;
        sw[ch] = pos_state[ch];
      end
      st.servo_a_angle = angle[0];
      st.servo_b_angle = angle[1];
      st.relay_drive = relay;
      st.led_drive = led;
      st.switch_states = sw;
      st.moving = busy;
      st.learning_active = learn_on;
      st.address_a_out = addr_a;
      st.address_b_out = addr_b;
      expected_status.push_back(st);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    task check_status(out_item_t got);
      out_item_t want;
      if (expected_status.size() == 0) begin
        report("status transaction with nothing expected");
        return;
      end
      want = expected_status.pop_front();
      compare_field("servo_a_angle", 16'(got.servo_a_angle), 16'(want.servo_a_angle));
      compare_field("servo_b_angle", 16'(got.servo_b_angle), 16'(want.servo_b_angle));
      compare_field("relay_drive", 16'(got.relay_drive), 16'(want.relay_drive));
      compare_field("led_drive", 16'(got.led_drive), 16'(want.led_drive));
      compare_field("switch_states", 16'(got.switch_states), 16'(want.switch_states));
      compare_field("moving", 16'(got.moving), 16'(want.moving));
      compare_field("learning_active", 16'(got.learning_active),
                    16'(want.learning_active));
      compare_field("address_a_out", 16'(got.address_a_out), 16'(want.address_a_out));
      compare_field("address_b_out", 16'(got.address_b_out), 16'(want.address_b_out));
    endtask
  endclass

endpackage

module servo_turnout_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stc_pkg::*;
  import stc_tb_pkg::*;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam logic [2:0] REG_UNUSED_LO   = 3'd6;
  localparam logic [2:0] REG_UNUSED_HI   = 3'd7;
  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         NUM_PHASES      = 8;
  localparam int         PHASE_ITEMS     = 105;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  servo_turnout_controller u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  turnout_scoreboard sb;
  int send_idle_pct;
  int stall_pct;
  int long_hold;
  int cycles;
  cfg_regs_t phase_regs [NUM_PHASES];
  int idle_send [4] = '{0, 75, 0, 21};
  int idle_recv [4] = '{0, 0, 75, 21};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Status receiver: checks each transaction and picks the next ready value.
  initial begin
    out_item_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.servo_a_angle = out_ch.servo_a_angle;
        got.servo_b_angle = out_ch.servo_b_angle;
        got.relay_drive = out_ch.relay_drive;
        got.led_drive = out_ch.led_drive;
        got.switch_states = out_ch.switch_states;
        got.moving = out_ch.moving;
        got.learning_active = out_ch.learning_active;
        got.address_a_out = out_ch.address_a_out;
        got.address_b_out = out_ch.address_b_out;
        sb.check_status(got);
      end
      if (long_hold > 0) begin
        out_ch.ready <= 1'b0;
        long_hold--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Valid is left high after acceptance so back-to-back transactions need no gap.
  task send_item(in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= it.op;
    in_ch.dcc_address <= it.dcc_address;
    in_ch.direction <= it.direction;
    in_ch.channel <= it.channel;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.apply_item(it);
  endtask

  task send_op(logic [2:0] op, logic [10:0] addr, logic dir, logic chan);
    in_item_t it;
    it.op = op;
    it.dcc_address = addr;
    it.direction = dir;
    it.channel = chan;
    send_item(it);
  endtask

  task wait_idle();
    in_ch.valid <= 1'b0;
    while (sb.expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task apb_write(logic [2:0] idx, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.write_reg(idx, value);
  endtask

  task load_regs(cfg_regs_t r);
    apb_write(REG_ANGLE_A_CLOSED, r.angle_a_closed);
    apb_write(REG_ANGLE_A_THROWN, r.angle_a_thrown);
    apb_write(REG_ANGLE_B_CLOSED, r.angle_b_closed);
    apb_write(REG_ANGLE_B_THROWN, r.angle_b_thrown);
    apb_write(REG_RELAY_PULSE, r.relay_pulse_ticks);
    apb_write(REG_STEP_DELAY, r.step_delay_ticks);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Mostly ticks so moves run to completion; while learning, commands are the most common op.
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    it.op = OP_TICK;
    it.dcc_address = 11'($urandom_range(0, 2047));
    it.direction = 1'($urandom_range(0, 1));
    it.channel = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (sb.learn_on) begin
      if (r < 45) begin
        it.op = OP_COMMAND;
        case ($urandom_range(0, 3))
          0: ;
          1: it.dcc_address = sb.addr_a;
          2: it.dcc_address = 11'($urandom_range(0, 7));
          default: it.dcc_address = 11'd2047;
        endcase
      end else if (r < 50) begin
        it.op = OP_LEARN_ABORT;
      end else if (r < 55) begin
        it.op = OP_TOGGLE;
      end else if (r < 58) begin
        it.op = OP_LEARN_START;
      end
    end else begin
      if (r < 62) begin
        it.op = OP_TICK;
      end else if (r < 74) begin
        it.op = OP_COMMAND;
        it.dcc_address = $urandom_range(0, 1) ? sb.addr_a : sb.addr_b;
      end else if (r < 78) begin
        it.op = OP_COMMAND;
      end else if (r < 86) begin
        it.op = OP_TOGGLE;
      end else if (r < 89) begin
        it.op = OP_LEARN_START;
      end else if (r < 91) begin
        it.op = OP_LEARN_ABORT;
      end else if (r < 94) begin
        it.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      end
    end
    return it;
  endfunction

  task run_directed();
    cfg_regs_t r;
    // Channel B's two end angles coincide, so its move has zero distance.
    r = '{8'd80, 8'd82, 8'd80, 8'd80, 8'd0, 8'd0};
    apb_write(REG_UNUSED_LO, 8'hFF);
    apb_write(REG_UNUSED_HI, 8'h00);
    load_regs(r);
    send_op(OP_UNUSED_FIRST, 11'd2047, 1'b1, 1'b1);
    send_op(OP_UNUSED_LAST, 11'd0, 1'b0, 1'b0);
    send_op(OP_LEARN_ABORT, 11'd3, 1'b1, 1'b0);
    send_op(OP_COMMAND, RST_ADDR_A, 1'b1, 1'b0);
    send_op(OP_COMMAND, RST_ADDR_B, 1'b1, 1'b1);
    send_op(OP_COMMAND, RST_ADDR_A, 1'b0, 1'b0);
    send_op(OP_TOGGLE, 11'd0, 1'b0, 1'b0);
    send_op(OP_TOGGLE, 11'd0, 1'b0, 1'b1);
    repeat (6) send_op(OP_TICK, 11'd0, 1'b0, 1'b0);
    send_op(OP_LEARN_START, 11'd0, 1'b0, 1'b0);
    send_op(OP_LEARN_START, 11'd0, 1'b0, 1'b0);
    send_op(OP_TOGGLE, 11'd0, 1'b0, 1'b0);
    send_op(OP_COMMAND, 11'd2047, 1'b1, 1'b0);
    send_op(OP_TICK, 11'd0, 1'b0, 1'b0);
    // Aborting here keeps the pending second slot, so the next address lands in B.
    send_op(OP_LEARN_ABORT, 11'd0, 1'b0, 1'b0);
    send_op(OP_LEARN_START, 11'd0, 1'b0, 1'b0);
    send_op(OP_COMMAND, 11'd0, 1'b1, 1'b1);
    send_op(OP_COMMAND, 11'd0, 1'b0, 1'b0);
    send_op(OP_COMMAND, 11'd2047, 1'b0, 1'b1);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold = 0;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_TICK;
    in_ch.dcc_address <= '0;
    in_ch.direction <= 1'b0;
    in_ch.channel <= 1'b0;

    phase_regs[0] = '{8'd78, 8'd84, 8'd76, 8'd83, 8'd1, 8'd1};
    phase_regs[1] = '{8'd0, 8'd180, 8'd180, 8'd0, 8'd0, 8'd0};
    phase_regs[2] = '{8'd90, 8'd91, 8'd92, 8'd90, 8'd255, 8'd0};
    phase_regs[3] = '{8'd95, 8'd100, 8'd85, 8'd80, 8'd3, 8'd255};
    phase_regs[4] = '{8'd100, 8'd104, 8'd80, 8'd83, 8'd0, 8'd2};
    phase_regs[5] = '{8'd180, 8'd178, 8'd0, 8'd2, 8'd5, 8'd1};
    phase_regs[6] = '{8'd80, 8'd120, 8'd80, 8'd120, 8'd75, 8'd0};
    phase_regs[7] = '{8'd60, 8'd62, 8'd64, 8'd66, 8'd1, 8'd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      load_regs(phase_regs[p]);
      send_idle_pct = idle_send[p % 4];
      stall_pct = idle_recv[p % 4];
      // Hold the receiver off while the sender keeps pushing, to fill the block.
      if (p == 0) long_hold = 250;
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    stall_pct = 0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
